### rtl/qrm_pkg.sv
package qrm_pkg;

	// Field widths
	localparam int QW    = 16;   // quaternion component
	localparam int EW    = 16;   // matrix entry, Q1.14
	localparam int PRODW = 32;   // 16x16 signed product
	localparam int NUMW  = 34;   // signed numerator, |num| <= 2^32
	localparam int MAGW  = 33;   // numerator magnitude and n2
	localparam int DENW  = 34;   // divisor 2*n2
	localparam int QBITS = 15;   // quotient bits, quotient <= 16384
	localparam int REMW  = MAGW + QBITS; // dividend 2*|num|*16384 + n2

	localparam int NLANE = 9;

	// Pipeline layout
	localparam int FRONT_STAGES = 3;
	localparam int PIPE_DEPTH   = FRONT_STAGES + QBITS + 1;

	// Q1.14 unity
	localparam int Q_ONE = 16384;

	// Matrix entry order e00,e01,e02,e10,e11,e12,e20,e21,e22
	localparam int LANE_E00 = 0;
	localparam int LANE_E11 = 4;
	localparam int LANE_E22 = 8;

endpackage

### rtl/qrm_in_if.sv
interface qrm_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [qrm_pkg::QW-1:0]     quat_w;
	logic signed [qrm_pkg::QW-1:0]     quat_x;
	logic signed [qrm_pkg::QW-1:0]     quat_y;
	logic signed [qrm_pkg::QW-1:0]     quat_z;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

### rtl/qrm_out_if.sv
interface qrm_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [qrm_pkg::EW-1:0]     e00;
	logic signed [qrm_pkg::EW-1:0]     e01;
	logic signed [qrm_pkg::EW-1:0]     e02;
	logic signed [qrm_pkg::EW-1:0]     e10;
	logic signed [qrm_pkg::EW-1:0]     e11;
	logic signed [qrm_pkg::EW-1:0]     e12;
	logic signed [qrm_pkg::EW-1:0]     e20;
	logic signed [qrm_pkg::EW-1:0]     e21;
	logic signed [qrm_pkg::EW-1:0]     e22;
	logic                              zero_norm;

	modport source (output valid, e00, e01, e02, e10, e11, e12, e20, e21, e22, zero_norm,
		input ready);
	modport sink   (input valid, e00, e01, e02, e10, e11, e12, e20, e21, e22, zero_norm,
		output ready);
endinterface

### rtl/quaternion_to_rotation_matrix_top.sv
// Quaternion to 3x3 rotation matrix, Q1.14 entries.
//
// in_q  : one beat per quaternion (quat_w, quat_x, quat_y, quat_z), signed,
//         any common scale. A beat moves when valid and ready are both high.
// out_m : one beat per quaternion with the nine entries e00..e22 in
//         -16384..16384 and zero_norm. An all-zero quaternion gives the
//         identity with zero_norm set.
// Pipeline: 3 stages of products, sums and dividend setup, 15 divider
// stages (one quotient bit per stage, nine lanes sharing the divisor),
// 1 stage of clamp and sign restore that is the output register.
// Throughput: one quaternion per cycle while the receiver does not stall.
// Stall: each stage holds while the one after it is full and stalled; empty
// stages keep filling, so input beats are still taken while a result waits
// until all 19 stages hold data.
// Reset: arst_n clears every stage valid bit; the pipeline comes up empty
// and in_q.ready is high in the first cycle after reset.
module quaternion_to_rotation_matrix_top (
	input  logic       clk,
	input  logic       arst_n,
	qrm_in_if.sink     in_q,
	qrm_out_if.source  out_m
);

	localparam int DEPTH = qrm_pkg::PIPE_DEPTH;
	localparam int FS    = qrm_pkg::FRONT_STAGES;
	localparam int QBITS = qrm_pkg::QBITS;
	localparam int NLANE = qrm_pkg::NLANE;

	logic [DEPTH-1:0] v_q;
	logic [DEPTH-1:0] en;

	logic [qrm_pkg::REMW-1:0]  dvd [NLANE];
	logic [qrm_pkg::DENW-1:0]  dvs;
	logic                      neg_f [NLANE];
	logic                      zero_f;
	logic [QBITS-1:0]          quo [NLANE];
	logic                      neg_d [NLANE];
	logic                      zero_d;
	logic signed [qrm_pkg::EW-1:0] e [NLANE];

	// A stage loads when it is empty or the stage after it moves on
	always_comb begin
		en[DEPTH-1] = !v_q[DEPTH-1] || out_m.ready;
		for (int k = DEPTH - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	// Advance valid bits with their data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= in_q.valid;
			end
			for (int k = 1; k < DEPTH; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign in_q.ready = en[0];

	qrm_front u_front (
		.clk  (clk),
		.en   (en[FS-1:0]),
		.w    (in_q.quat_w),
		.x    (in_q.quat_x),
		.y    (in_q.quat_y),
		.z    (in_q.quat_z),
		.dvd  (dvd),
		.dvs  (dvs),
		.neg  (neg_f),
		.zero (zero_f)
	);

	qrm_divider u_div (
		.clk    (clk),
		.en     (en[FS+QBITS-1:FS]),
		.dvd    (dvd),
		.dvs    (dvs),
		.neg_i  (neg_f),
		.zero_i (zero_f),
		.quo    (quo),
		.neg_o  (neg_d),
		.zero_o (zero_d)
	);

	qrm_finish u_finish (
		.clk       (clk),
		.en        (en[DEPTH-1]),
		.quo       (quo),
		.neg       (neg_d),
		.zero      (zero_d),
		.e         (e),
		.zero_norm (out_m.zero_norm)
	);

	assign out_m.valid = v_q[DEPTH-1];
	assign out_m.e00   = e[0];
	assign out_m.e01   = e[1];
	assign out_m.e02   = e[2];
	assign out_m.e10   = e[3];
	assign out_m.e11   = e[4];
	assign out_m.e12   = e[5];
	assign out_m.e20   = e[6];
	assign out_m.e21   = e[7];
	assign out_m.e22   = e[8];

	// A zero quaternion reports the identity
	a_zero_identity: assert property (@(posedge clk) disable iff (!arst_n)
		out_m.valid && out_m.zero_norm |->
			out_m.e00 == qrm_pkg::EW'(qrm_pkg::Q_ONE) && out_m.e11 == qrm_pkg::EW'(qrm_pkg::Q_ONE)
			&& out_m.e22 == qrm_pkg::EW'(qrm_pkg::Q_ONE) && out_m.e01 == '0 && out_m.e12 == '0)
		else $error("zero quaternion without identity output");

	// Entries e00 and e01 stay within the Q1.14 unit range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_m.valid |->
			out_m.e00 <= qrm_pkg::EW'(qrm_pkg::Q_ONE) && out_m.e00 >= -qrm_pkg::EW'(qrm_pkg::Q_ONE)
			&& out_m.e01 <= qrm_pkg::EW'(qrm_pkg::Q_ONE) && out_m.e01 >= -qrm_pkg::EW'(qrm_pkg::Q_ONE))
		else $error("matrix entry outside unit range");

	// The first divider stage keeps its beat while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[FS] && !en[FS] |=> v_q[FS])
		else $error("stalled divider stage lost its beat");

	// The output stage, when it moves on while its source is empty, becomes a bubble
	a_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		en[DEPTH-1] && !v_q[DEPTH-2] |=> !v_q[DEPTH-1])
		else $error("output stage repeated a beat");

endmodule

### rtl/qrm_front.sv
module qrm_front (
	input  logic                                   clk,
	input  logic [qrm_pkg::FRONT_STAGES-1:0]       en,
	input  logic signed [qrm_pkg::QW-1:0]          w,
	input  logic signed [qrm_pkg::QW-1:0]          x,
	input  logic signed [qrm_pkg::QW-1:0]          y,
	input  logic signed [qrm_pkg::QW-1:0]          z,
	output logic [qrm_pkg::REMW-1:0]               dvd [qrm_pkg::NLANE],
	output logic [qrm_pkg::DENW-1:0]               dvs,
	output logic                                   neg [qrm_pkg::NLANE],
	output logic                                   zero
);

	localparam int PRODW = qrm_pkg::PRODW;
	localparam int NUMW  = qrm_pkg::NUMW;
	localparam int MAGW  = qrm_pkg::MAGW;
	localparam int QBITS = qrm_pkg::QBITS;
	localparam int NLANE = qrm_pkg::NLANE;

	logic signed [PRODW-1:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [PRODW-1:0] xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic                    zero_s1;

	logic [MAGW-1:0]         n2_s2;
	logic signed [NUMW-1:0]  num_s2 [NLANE];
	logic                    zero_s2;

	logic [qrm_pkg::REMW-1:0] dvd_s3 [NLANE];
	logic [qrm_pkg::DENW-1:0] dvs_s3;
	logic                     neg_s3 [NLANE];
	logic                     zero_s3;

	logic signed [NUMW-1:0]  num_c [NLANE];
	logic [MAGW-1:0]         n2_c;

	// Form the ten products
	always_ff @(posedge clk) begin
		if (en[0]) begin
			ww_s1   <= w * w;
			xx_s1   <= x * x;
			yy_s1   <= y * y;
			zz_s1   <= z * z;
			xy_s1   <= x * y;
			xz_s1   <= x * z;
			yz_s1   <= y * z;
			wx_s1   <= w * x;
			wy_s1   <= w * y;
			wz_s1   <= w * z;
			zero_s1 <= (w == '0) && (x == '0) && (y == '0) && (z == '0);
		end
	end

	// Combine products into the squared norm and nine numerators
	always_comb begin
		n2_c = MAGW'({1'b0, ww_s1}) + MAGW'({1'b0, xx_s1})
			+ MAGW'({1'b0, yy_s1}) + MAGW'({1'b0, zz_s1});
		num_c[0] = NUMW'(ww_s1) + NUMW'(xx_s1) - NUMW'(yy_s1) - NUMW'(zz_s1);
		num_c[1] = (NUMW'(xy_s1) - NUMW'(wz_s1)) <<< 1;
		num_c[2] = (NUMW'(xz_s1) + NUMW'(wy_s1)) <<< 1;
		num_c[3] = (NUMW'(xy_s1) + NUMW'(wz_s1)) <<< 1;
		num_c[4] = NUMW'(ww_s1) - NUMW'(xx_s1) + NUMW'(yy_s1) - NUMW'(zz_s1);
		num_c[5] = (NUMW'(yz_s1) - NUMW'(wx_s1)) <<< 1;
		num_c[6] = (NUMW'(xz_s1) - NUMW'(wy_s1)) <<< 1;
		num_c[7] = (NUMW'(yz_s1) + NUMW'(wx_s1)) <<< 1;
		num_c[8] = NUMW'(ww_s1) - NUMW'(xx_s1) - NUMW'(yy_s1) + NUMW'(zz_s1);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			n2_s2   <= n2_c;
			num_s2  <= num_c;
			zero_s2 <= zero_s1;
		end
	end

	// Split sign and magnitude, add the rounding half: dvd = 2*|num|*2^14 + n2
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int l = 0; l < NLANE; l++) begin
				neg_s3[l] <= num_s2[l][NUMW-1];
				dvd_s3[l] <= {(num_s2[l][NUMW-1] ? MAGW'(-num_s2[l]) : MAGW'(num_s2[l])),
					{QBITS{1'b0}}} + qrm_pkg::REMW'(n2_s2);
			end
			dvs_s3  <= {n2_s2, 1'b0};
			zero_s3 <= zero_s2;
		end
	end

	assign dvd  = dvd_s3;
	assign dvs  = dvs_s3;
	assign neg  = neg_s3;
	assign zero = zero_s3;

endmodule

### rtl/qrm_divider.sv
module qrm_divider (
	input  logic                               clk,
	input  logic [qrm_pkg::QBITS-1:0]          en,
	input  logic [qrm_pkg::REMW-1:0]           dvd [qrm_pkg::NLANE],
	input  logic [qrm_pkg::DENW-1:0]           dvs,
	input  logic                               neg_i [qrm_pkg::NLANE],
	input  logic                               zero_i,
	output logic [qrm_pkg::QBITS-1:0]          quo [qrm_pkg::NLANE],
	output logic                               neg_o [qrm_pkg::NLANE],
	output logic                               zero_o
);

	localparam int QBITS = qrm_pkg::QBITS;
	localparam int REMW  = qrm_pkg::REMW;
	localparam int DENW  = qrm_pkg::DENW;
	localparam int NLANE = qrm_pkg::NLANE;

	logic [REMW-1:0]  rem_s  [QBITS][NLANE];
	logic [QBITS-1:0] quo_s  [QBITS][NLANE];
	logic             neg_s  [QBITS][NLANE];
	logic [DENW-1:0]  dvs_s  [QBITS];
	logic             zero_s [QBITS];

	// One restoring step per stage, most significant quotient bit first
	for (genvar j = 0; j < QBITS; j++) begin : g_step
		logic [REMW-1:0]  r_in [NLANE];
		logic [QBITS-1:0] q_in [NLANE];
		logic             n_in [NLANE];
		logic [DENW-1:0]  d_in;
		logic             z_in;
		logic [REMW-1:0]  d_sh;

		if (j == 0) begin : g_head
			assign r_in = dvd;
			assign n_in = neg_i;
			assign d_in = dvs;
			assign z_in = zero_i;
			for (genvar l = 0; l < NLANE; l++) begin : g_q0
				assign q_in[l] = '0;
			end
		end else begin : g_body
			assign r_in = rem_s[j-1];
			assign q_in = quo_s[j-1];
			assign n_in = neg_s[j-1];
			assign d_in = dvs_s[j-1];
			assign z_in = zero_s[j-1];
		end

		assign d_sh = REMW'(d_in) << (QBITS - 1 - j);

		for (genvar l = 0; l < NLANE; l++) begin : g_lane
			logic ge;
			assign ge = (r_in[l] >= d_sh);

			always_ff @(posedge clk) begin
				if (en[j]) begin
					rem_s[j][l] <= ge ? (r_in[l] - d_sh) : r_in[l];
					quo_s[j][l] <= {q_in[l][QBITS-2:0], ge};
					neg_s[j][l] <= n_in[l];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				dvs_s[j]  <= d_in;
				zero_s[j] <= z_in;
			end
		end
	end

	assign quo    = quo_s[QBITS-1];
	assign neg_o  = neg_s[QBITS-1];
	assign zero_o = zero_s[QBITS-1];

endmodule

### rtl/qrm_finish.sv
module qrm_finish (
	input  logic                               clk,
	input  logic                               en,
	input  logic [qrm_pkg::QBITS-1:0]          quo [qrm_pkg::NLANE],
	input  logic                               neg [qrm_pkg::NLANE],
	input  logic                               zero,
	output logic signed [qrm_pkg::EW-1:0]      e [qrm_pkg::NLANE],
	output logic                               zero_norm
);

	localparam int EW    = qrm_pkg::EW;
	localparam int QBITS = qrm_pkg::QBITS;
	localparam int NLANE = qrm_pkg::NLANE;

	logic signed [EW-1:0] e_q [NLANE];
	logic                 zero_norm_q;
	logic signed [EW-1:0] e_c [NLANE];

	// Clamp, restore sign, substitute identity for a zero quaternion
	always_comb begin
		for (int l = 0; l < NLANE; l++) begin
			logic [QBITS-1:0] qs;
			qs = (quo[l] > QBITS'(qrm_pkg::Q_ONE)) ? QBITS'(qrm_pkg::Q_ONE) : quo[l];
			e_c[l] = neg[l] ? -EW'(qs) : EW'(qs);
			if (zero) begin
				e_c[l] = ((l == qrm_pkg::LANE_E00) || (l == qrm_pkg::LANE_E11)
					|| (l == qrm_pkg::LANE_E22)) ? EW'(qrm_pkg::Q_ONE) : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_q         <= e_c;
			zero_norm_q <= zero;
		end
	end

	assign e         = e_q;
	assign zero_norm = zero_norm_q;

endmodule
